// ===== design/ata_tf_pkg.sv =====
// Shared types and constants of the ATA task file register interface.
package ata_tf_pkg;

  // Request codes carried by req_type
  localparam logic [3:0] REQ_HOST_WR    = 4'd0;
  localparam logic [3:0] REQ_HOST_RD    = 4'd1;
  localparam logic [3:0] REQ_RESET_DONE = 4'd2;
  localparam logic [3:0] REQ_CMD_DONE   = 4'd3;
  localparam logic [3:0] REQ_PIO_RD     = 4'd4;
  localparam logic [3:0] REQ_PIO_WR     = 4'd5;
  localparam logic [3:0] REQ_BUF_WR     = 4'd6;
  localparam logic [3:0] REQ_BUF_RD     = 4'd7;
  localparam logic [3:0] REQ_TASK_RD    = 4'd8;

  // Register block select and offsets
  localparam logic       CS_CMD    = 1'b0;
  localparam logic       CS_CTRL   = 1'b1;
  localparam logic [2:0] RA_DATA   = 3'd0;
  localparam logic [2:0] RA_ERROR  = 3'd1;
  localparam logic [2:0] RA_DEVCTL = 3'd6;
  localparam logic [2:0] RA_CMD    = 3'd7;
  localparam int         TF_REGS   = 7;

  // Status, error and device control encodings
  localparam int         ST_BSY_BIT       = 7;
  localparam int         ST_DRQ_BIT       = 3;
  localparam int         ST_ERR_BIT       = 0;
  localparam logic [7:0] STATUS_RESET     = 8'h80;
  localparam logic [7:0] STATUS_READY     = 8'h50;
  localparam logic [7:0] ERROR_DIAG_OK    = 8'h01;
  localparam logic [7:0] DONE_STATUS_MASK = 8'h77;
  localparam int         DC_SRST_BIT      = 2;
  localparam int         DC_NIEN_BIT      = 1;
  localparam logic [15:0] RD_FLOAT        = 16'hFFFF;

  // Configuration port
  localparam int         PADDR_W     = 3;
  localparam logic       CFG_BYTE_MODE = 1'b0;

  // Widest buffer byte address supported
  localparam int BUF_ADDR_W = 16;

  typedef enum logic [2:0] {
    XM_IDLE  = 3'b001,
    XM_READ  = 3'b010,
    XM_WRITE = 3'b100
  } xfer_mode_t;

  typedef enum logic [1:0] {
    AE_OK    = 2'd0,
    AE_BUSY  = 2'd1,
    AE_NOPIO = 2'd2,
    AE_ADDR  = 2'd3
  } aerr_t;

  // Two byte lanes into the sector buffer; lane 1 sits one byte above lane 0
  typedef struct packed {
    logic                  we0;
    logic                  we1;
    logic                  re0;
    logic                  re1;
    logic [BUF_ADDR_W-1:0] addr0;
    logic [BUF_ADDR_W-1:0] addr1;
    logic [15:0]           wdata;
  } buf_req_t;

  typedef struct packed {
    logic [15:0] rd_base;
    logic        lo_mem;
    logic        hi_mem;
    logic        irq;
    logic        busy;
    logic        drq;
    logic        reset_req;
    logic        cmd_req;
    logic [7:0]  cmd_code;
    logic        wfin;
    aerr_t       aerr;
  } res_t;

endpackage

// ===== design/ata_tf_buf.sv =====
// Sector buffer: even and odd byte banks with registered read data.
module ata_tf_buf #(
  parameter int BUFFER_BYTES = 512
) (
  input  logic                 clk,
  input  ata_tf_pkg::buf_req_t req,
  output logic [7:0]           rd_lo,
  output logic [7:0]           rd_hi
);

  localparam int ROWS = (BUFFER_BYTES + 1) / 2;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [7:0] bank0 [ROWS];
  logic [7:0] bank1 [ROWS];

  logic          swap;
  logic          swap_q;
  logic [RW-1:0] row0;
  logic [RW-1:0] row1;
  logic          b0_we, b1_we, b0_re, b1_re;
  logic [RW-1:0] b0_row, b1_row;
  logic [7:0]    b0_wd, b1_wd;
  logic [7:0]    b0_q, b1_q;

  // lane 0 on an odd byte lands in the odd bank
  assign swap = req.addr0[0];
  assign row0 = RW'(req.addr0 >> 1);
  assign row1 = RW'(req.addr1 >> 1);

  assign b0_we  = swap ? req.we1 : req.we0;
  assign b1_we  = swap ? req.we0 : req.we1;
  assign b0_re  = swap ? req.re1 : req.re0;
  assign b1_re  = swap ? req.re0 : req.re1;
  assign b0_row = swap ? row1 : row0;
  assign b1_row = swap ? row0 : row1;
  assign b0_wd  = swap ? req.wdata[15:8] : req.wdata[7:0];
  assign b1_wd  = swap ? req.wdata[7:0]  : req.wdata[15:8];

  always_ff @(posedge clk) begin
    if (b0_we) begin
      bank0[b0_row] <= b0_wd;
    end
    if (b0_re) begin
      b0_q <= bank0[b0_row];
    end
  end

  always_ff @(posedge clk) begin
    if (b1_we) begin
      bank1[b1_row] <= b1_wd;
    end
    if (b1_re) begin
      b1_q <= bank1[b1_row];
    end
  end

  always_ff @(posedge clk) begin
    if (req.re0 || req.re1) begin
      swap_q <= swap;
    end
  end

  assign rd_lo = swap_q ? b1_q : b0_q;
  assign rd_hi = swap_q ? b0_q : b1_q;

endmodule

// ===== design/ata_tf_regs.sv =====
// Task file, status, interrupt and PIO transfer state with per-request decode.
module ata_tf_regs #(
  parameter int BUFFER_BYTES = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [3:0]           req_type,
  input  logic                 chip_select,
  input  logic [2:0]           reg_addr,
  input  logic [15:0]          wr_data,
  input  logic [7:0]           done_status,
  input  logic [7:0]           done_error,
  input  logic [9:0]           pio_length,
  input  logic [8:0]           buffer_index,
  input  logic                 byte_mode,
  output ata_tf_pkg::buf_req_t buf_req,
  output ata_tf_pkg::res_t     result
);

  logic [7:0] tf_regs [ata_tf_pkg::TF_REGS];
  logic [7:0] tf_next [ata_tf_pkg::TF_REGS];
  logic [7:0] status, status_next;
  logic [7:0] error, error_next;
  logic       irq_pend, irq_pend_next;
  logic       irq_en, irq_en_next;
  logic       srst, srst_next;
  ata_tf_pkg::xfer_mode_t mode, mode_next;
  logic [9:0] pos, pos_next;
  logic [9:0] len, len_next;

  logic [8:0]  bidx;
  logic        busy;
  logic [2:0]  eff_addr;
  logic [2:0]  tidx;
  logic [7:0]  tf_rd;
  logic        v0, v1;
  logic [10:0] pos_inc;
  ata_tf_pkg::buf_req_t req_c;

  // buffer index modulo the buffer size, by shifted compare and subtract
  always_comb begin
    bidx = buffer_index;
    for (int k = 7; k >= 0; k--) begin
      if ({23'd0, bidx} >= (32'(BUFFER_BYTES) << k)) begin
        bidx = bidx - 9'(32'(BUFFER_BYTES) << k);
      end
    end
  end

  assign busy     = status[ata_tf_pkg::ST_BSY_BIT];
  assign eff_addr = busy ? ata_tf_pkg::RA_CMD : reg_addr;
  assign tidx     = (req_type == ata_tf_pkg::REQ_TASK_RD) ? reg_addr : 3'(eff_addr - 3'd1);
  assign tf_rd    = (tidx < 3'(ata_tf_pkg::TF_REGS)) ? tf_regs[tidx] : 8'd0;

  // data port bytes: lane 0 at the position, lane 1 one above in word mode
  assign pos_inc = 11'(pos) + 11'd1;
  assign v0      = pos < len;
  assign v1      = v0 && !byte_mode && (pos_inc < 11'(len));

  always_comb begin
    tf_next       = tf_regs;
    status_next   = status;
    error_next    = error;
    irq_pend_next = irq_pend;
    irq_en_next   = irq_en;
    srst_next     = srst;
    mode_next     = mode;
    pos_next      = pos;
    len_next      = len;

    req_c       = '0;
    req_c.addr0 = ata_tf_pkg::BUF_ADDR_W'(pos);
    req_c.addr1 = ata_tf_pkg::BUF_ADDR_W'(pos_inc);
    req_c.wdata = wr_data;

    result           = '0;
    result.aerr      = ata_tf_pkg::AE_OK;

    unique case (req_type)
      ata_tf_pkg::REQ_HOST_WR: begin
        if (chip_select == ata_tf_pkg::CS_CMD) begin
          if (busy) begin
            result.aerr = ata_tf_pkg::AE_BUSY;
          end else if (reg_addr == ata_tf_pkg::RA_DATA) begin
            if (mode != ata_tf_pkg::XM_WRITE) begin
              result.aerr = ata_tf_pkg::AE_NOPIO;
            end else begin
              req_c.we0 = v0;
              req_c.we1 = v1;
              pos_next  = pos + 10'(v0) + 10'(v1);
              if (pos_next < len) begin
                status_next[ata_tf_pkg::ST_DRQ_BIT] = 1'b1;
                irq_pend_next = 1'b1;
              end else begin
                status_next[ata_tf_pkg::ST_DRQ_BIT] = 1'b0;
                result.wfin = 1'b1;
                mode_next   = ata_tf_pkg::XM_IDLE;
              end
            end
          end else begin
            tf_next[3'(reg_addr - 3'd1)] = wr_data[7:0];
            if (reg_addr == ata_tf_pkg::RA_CMD) begin
              status_next[ata_tf_pkg::ST_BSY_BIT] = 1'b1;
              result.cmd_req  = 1'b1;
              result.cmd_code = wr_data[7:0];
            end
          end
        end else if (reg_addr == ata_tf_pkg::RA_DEVCTL) begin
          irq_en_next = !wr_data[ata_tf_pkg::DC_NIEN_BIT];
          srst_next   = wr_data[ata_tf_pkg::DC_SRST_BIT];
          // release of soft reset starts a device reset
          if (!wr_data[ata_tf_pkg::DC_SRST_BIT] && srst) begin
            status_next[ata_tf_pkg::ST_BSY_BIT] = 1'b1;
            result.reset_req = 1'b1;
          end
        end else begin
          result.aerr = ata_tf_pkg::AE_ADDR;
        end
      end

      ata_tf_pkg::REQ_HOST_RD: begin
        if (chip_select == ata_tf_pkg::CS_CMD) begin
          if (eff_addr == ata_tf_pkg::RA_DATA) begin
            if (mode != ata_tf_pkg::XM_READ) begin
              result.rd_base = ata_tf_pkg::RD_FLOAT;
              result.aerr    = ata_tf_pkg::AE_NOPIO;
            end else begin
              req_c.re0     = v0;
              req_c.re1     = v1;
              result.lo_mem = v0;
              result.hi_mem = v1;
              pos_next      = pos + 10'(v0) + 10'(v1);
              if (pos_next < len) begin
                status_next[ata_tf_pkg::ST_DRQ_BIT] = 1'b1;
                irq_pend_next = 1'b1;
              end else begin
                status_next[ata_tf_pkg::ST_DRQ_BIT] = 1'b0;
                mode_next = ata_tf_pkg::XM_IDLE;
              end
            end
          end else if (eff_addr == ata_tf_pkg::RA_ERROR) begin
            result.rd_base = 16'(error);
          end else if (eff_addr == ata_tf_pkg::RA_CMD) begin
            irq_pend_next  = 1'b0;
            result.rd_base = 16'(status);
          end else begin
            result.rd_base = 16'(tf_rd);
          end
        end else if (reg_addr == ata_tf_pkg::RA_DEVCTL) begin
          result.rd_base = 16'(status);
        end else begin
          result.rd_base = ata_tf_pkg::RD_FLOAT;
          result.aerr    = ata_tf_pkg::AE_ADDR;
        end
      end

      ata_tf_pkg::REQ_RESET_DONE: begin
        status_next = ata_tf_pkg::STATUS_READY;
        error_next  = ata_tf_pkg::ERROR_DIAG_OK;
        for (int i = 0; i < ata_tf_pkg::TF_REGS; i++) begin
          tf_next[i] = 8'd0;
        end
      end

      ata_tf_pkg::REQ_CMD_DONE: begin
        status_next = (status & (8'd1 << ata_tf_pkg::ST_DRQ_BIT))
                    | (done_status & ata_tf_pkg::DONE_STATUS_MASK);
        error_next  = done_error;
        if (!done_status[ata_tf_pkg::ST_ERR_BIT]) begin
          irq_pend_next = 1'b1;
        end
      end

      ata_tf_pkg::REQ_PIO_RD, ata_tf_pkg::REQ_PIO_WR: begin
        if ({7'd0, pio_length} > 17'(BUFFER_BYTES)) begin
          len_next = 10'(BUFFER_BYTES);
        end else begin
          len_next = pio_length;
        end
        pos_next = 10'd0;
        if (len_next != 10'd0) begin
          mode_next = (req_type == ata_tf_pkg::REQ_PIO_RD) ? ata_tf_pkg::XM_READ
                                                            : ata_tf_pkg::XM_WRITE;
          status_next[ata_tf_pkg::ST_DRQ_BIT] = 1'b1;
        end else begin
          // empty transfer ends at once; an active write reports completion
          status_next[ata_tf_pkg::ST_DRQ_BIT] = 1'b0;
          result.wfin = (mode == ata_tf_pkg::XM_WRITE);
          mode_next   = ata_tf_pkg::XM_IDLE;
        end
      end

      ata_tf_pkg::REQ_BUF_WR: begin
        req_c.we0   = 1'b1;
        req_c.addr0 = ata_tf_pkg::BUF_ADDR_W'(bidx);
      end

      ata_tf_pkg::REQ_BUF_RD: begin
        req_c.re0     = 1'b1;
        req_c.addr0   = ata_tf_pkg::BUF_ADDR_W'(bidx);
        result.lo_mem = 1'b1;
      end

      ata_tf_pkg::REQ_TASK_RD: begin
        if (reg_addr != ata_tf_pkg::RA_CMD) begin
          result.rd_base = 16'(tf_rd);
        end else begin
          result.aerr = ata_tf_pkg::AE_ADDR;
        end
      end

      default: begin
      end
    endcase

    result.irq  = irq_pend_next && irq_en_next;
    result.busy = status_next[ata_tf_pkg::ST_BSY_BIT];
    result.drq  = status_next[ata_tf_pkg::ST_DRQ_BIT];

    buf_req     = req_c;
    buf_req.we0 = req_c.we0 && accept;
    buf_req.we1 = req_c.we1 && accept;
    buf_req.re0 = req_c.re0 && accept;
    buf_req.re1 = req_c.re1 && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ata_tf_pkg::TF_REGS; i++) begin
        tf_regs[i] <= 8'd0;
      end
      status   <= ata_tf_pkg::STATUS_RESET;
      error    <= 8'd0;
      irq_pend <= 1'b0;
      irq_en   <= 1'b0;
      srst     <= 1'b0;
      mode     <= ata_tf_pkg::XM_IDLE;
      pos      <= 10'd0;
      len      <= 10'd0;
    end else if (accept) begin
      tf_regs  <= tf_next;
      status   <= status_next;
      error    <= error_next;
      irq_pend <= irq_pend_next;
      irq_en   <= irq_en_next;
      srst     <= srst_next;
      mode     <= mode_next;
      pos      <= pos_next;
      len      <= len_next;
    end
  end

endmodule

// ===== design/ata_task_file_register_interface_unit.sv =====
// Top level of the ATA task file register interface: handshakes, config port, result register.
//
//   channel   direction  handshake                  payload
//   request   in         in_valid / in_stall        req_type .. buffer_index
//   result    out        out_valid / out_stall      rd_data .. access_error
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One request is taken per cycle unless a stalled result holds it; its result appears
// in the result register in the next cycle. Buffer reads use the registered bank outputs.
// Synchronous reset sets BSY in status and clears the task file and transfer state;
// the sector buffer is not cleared. A stalled result holds, and a new request is
// taken in the same cycle the waiting result leaves.
module ata_task_file_register_interface_unit #(
  parameter int BUFFER_BYTES = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [3:0]                     req_type,
  input  logic                           chip_select,
  input  logic [2:0]                     reg_addr,
  input  logic [15:0]                    wr_data,
  input  logic [7:0]                     done_status,
  input  logic [7:0]                     done_error,
  input  logic [9:0]                     pio_length,
  input  logic [8:0]                     buffer_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    rd_data,
  output logic                           irq,
  output logic                           busy_res,
  output logic                           drq,
  output logic                           reset_request,
  output logic                           command_request,
  output logic [7:0]                     command_code,
  output logic                           write_finished,
  output logic [1:0]                     access_error,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ata_tf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic                 accept;
  logic                 byte_mode;
  ata_tf_pkg::buf_req_t buf_req;
  ata_tf_pkg::res_t     res;
  ata_tf_pkg::res_t     res_q;
  logic [7:0]           rd_lo;
  logic [7:0]           rd_hi;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ata_tf_pkg::CFG_BYTE_MODE) ? {31'd0, byte_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == ata_tf_pkg::CFG_BYTE_MODE) begin
      byte_mode <= pwdata[0];
    end
  end

  ata_tf_regs #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_regs (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .req_type     (req_type),
    .chip_select  (chip_select),
    .reg_addr     (reg_addr),
    .wr_data      (wr_data),
    .done_status  (done_status),
    .done_error   (done_error),
    .pio_length   (pio_length),
    .buffer_index (buffer_index),
    .byte_mode    (byte_mode),
    .buf_req      (buf_req),
    .result       (res)
  );

  ata_tf_buf #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_buf (
    .clk   (clk),
    .req   (buf_req),
    .rd_lo (rd_lo),
    .rd_hi (rd_hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign rd_data         = {res_q.hi_mem ? rd_hi : res_q.rd_base[15:8],
                            res_q.lo_mem ? rd_lo : res_q.rd_base[7:0]};
  assign irq             = res_q.irq;
  assign busy_res        = res_q.busy;
  assign drq             = res_q.drq;
  assign reset_request   = res_q.reset_req;
  assign command_request = res_q.cmd_req;
  assign command_code    = res_q.cmd_code;
  assign write_finished  = res_q.wfin;
  assign access_error    = res_q.aerr;

endmodule
